FILE: rtl/core/gdp_pkg.sv
// ----------------------------------------------------------------------------
// gdp_pkg: shared types and constants for the gap detector
// Holds the payload structs, operation codes, controller states, the
// command/status bundles between controller and datapath, and percentile ratios.
// ----------------------------------------------------------------------------
package gdp_pkg;

  // operation codes
  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_SAMPLE = 2'd1;
  localparam logic [1:0] OP_STOP   = 2'd2;

  localparam int COUNT_W = 13;
  localparam int TS_W    = 64;

  // order-statistic lanes
  localparam int N_LANE      = 8;
  localparam int LANE_MIN    = 0;
  localparam int LANE_MEDIAN = 1;
  localparam int LANE_P90    = 2;
  localparam int LANE_P99    = 3;
  localparam int LANE_P999   = 4;
  localparam int LANE_P9999  = 5;
  localparam int LANE_P99999 = 6;
  localparam int LANE_MAX    = 7;

  localparam logic [5:0] BIT_TOP = 6'd63;

  typedef struct packed {
    logic [1:0]      operation;
    logic [TS_W-1:0] timestamp;
  } in_word_t;

  typedef struct packed {
    logic [TS_W-1:0]    runtime;
    logic [COUNT_W-1:0] gap_count;
    logic [TS_W-1:0]    gap_min;
    logic [TS_W-1:0]    gap_median;
    logic [TS_W-1:0]    gap_mean;
    logic [TS_W-1:0]    gap_p90;
    logic [TS_W-1:0]    gap_p99;
    logic [TS_W-1:0]    gap_p999;
    logic [TS_W-1:0]    gap_p9999;
    logic [TS_W-1:0]    gap_p99999;
    logic [TS_W-1:0]    gap_max;
    logic [TS_W-1:0]    gap_total;
  } out_word_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV_WAIT,
    S_SCAN_INIT,
    S_PASS,
    S_DRAIN,
    S_UPD,
    S_REPORT
  } ctrl_state_t;

  // controller -> datapath
  typedef struct packed {
    logic       take_start;
    logic       take_sample;
    logic       take_stop;
    logic       div_start;
    logic       div_save;
    logic       scan_clear;
    logic       rd_en;
    logic       lane_update;
    logic [5:0] bit_idx;
    logic       out_load;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;
    logic div_done;
    logic addr_last;
    logic out_free;
  } dp_sts_t;

  // percentile index floor(n*(den-1)/den) = n - ceil(n/den), for n below 2^20+1;
  // ceil(n/den) = floor((n+den-1)/den) by reciprocal multiply, exact below 2^21
  function automatic logic [20:0] pct_index(input logic [20:0] n, input logic [2:0] lane);
    logic [20:0] x;
    logic [21:0] m;
    logic [5:0]  s;
    logic [42:0] p;
    logic [20:0] up;
    unique case (lane)
      3'(LANE_P90): begin
        x = n + 21'd9;     m = 22'd3355444; s = 6'd25;
      end
      3'(LANE_P99): begin
        x = n + 21'd99;    m = 22'd2684355; s = 6'd28;
      end
      3'(LANE_P999): begin
        x = n + 21'd999;   m = 22'd2147484; s = 6'd31;
      end
      3'(LANE_P9999): begin
        x = n + 21'd9999;  m = 22'd3435974; s = 6'd35;
      end
      default: begin
        x = n + 21'd99999; m = 22'd2748780; s = 6'd38;
      end
    endcase
    p  = 43'(x) * 43'(m);
    up = 21'(p >> s);
    return n - up;
  endfunction

endpackage

FILE: rtl/core/gap_detector_with_percentile_stats.sv
// Start, sample and unused-code words go in every cycle while no stop report runs.
// On a stop with recorded gaps the block runs the mean divide, then 64 store passes,
// one per result bit, then loads the report; with none it reports zero statistics.
// No word is taken during a stop report; a finished report waits in the output register.
// Reset (rst_n low, synchronous) clears stamps, count, total, threshold and handshakes;
// the gap store is not cleared.
// ----------------------------------------------------------------------------
// gap_detector_with_percentile_stats: interruption-gap monitor
// Records timestamp gaps at or above a threshold and reports runtime, count,
// min, median, mean, percentiles, max and total on stop.
// ----------------------------------------------------------------------------
module gap_detector_with_percentile_stats import gdp_pkg::*; #(
  parameter int GAP_CAPACITY = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  gdp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.operation),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  gdp_datapath #(
    .GAP_CAPACITY (GAP_CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: rtl/core/gdp_div.sv
// ----------------------------------------------------------------------------
// gdp_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gdp_div import gdp_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [TS_W-1:0] dividend,
  input  logic [TS_W-1:0] divisor,
  output logic            done,
  output logic [TS_W-1:0] quotient
);

  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [5:0]      step_r, step_nxt;
  logic [TS_W-1:0] rem_r, rem_nxt;
  logic [TS_W-1:0] quo_r, quo_nxt;
  logic [TS_W-1:0] dvs_r, dvs_nxt;
  logic [TS_W:0]   shifted;

  // one restoring step
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    shifted  = {rem_r, quo_r[TS_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (shifted >= {1'b0, dvs_r}) begin
        rem_nxt = TS_W'(shifted - {1'b0, dvs_r});
        quo_nxt = {quo_r[TS_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[TS_W-1:0];
        quo_nxt = {quo_r[TS_W-2:0], 1'b0};
      end
      step_nxt = step_r + 6'd1;
      if (step_r == BIT_TOP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

FILE: rtl/core/gdp_datapath.sv
// ----------------------------------------------------------------------------
// gdp_datapath: gap store, running state and order-statistic lanes
// Records gaps into the store, runs the mean divide at stop and counts, per lane,
// stored gaps below a trial value to build each order statistic bit by bit.
// ----------------------------------------------------------------------------
module gdp_datapath import gdp_pkg::*; #(
  parameter int GAP_CAPACITY = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  output dp_sts_t     sts,
  input  in_word_t    in_data,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_data
);

  localparam int AW = (GAP_CAPACITY > 1) ? $clog2(GAP_CAPACITY) : 1;
  localparam int NW = $clog2(GAP_CAPACITY + 1);

  // run state
  logic [31:0]     thr_r;
  logic [TS_W-1:0] prev_r, start_r, total_r;
  logic [NW-1:0]   cnt_r;
  // stop snapshot
  logic [NW-1:0]   n_r;
  logic [TS_W-1:0] runtime_r, mean_r;
  // lanes
  logic [NW-1:0]   k_r   [N_LANE];
  logic [TS_W-1:0] ans_r [N_LANE];
  logic [NW-1:0]   lt_r  [N_LANE];
  logic [TS_W-1:0] trial [N_LANE];
  // store and read port
  logic [TS_W-1:0] mem [GAP_CAPACITY];
  logic [AW-1:0]   addr_r;
  logic            rd_vld_r;
  logic [TS_W-1:0] rdata_r;
  // output register
  logic            out_valid_r;
  out_word_t       out_r;

  logic [TS_W-1:0] gap;
  logic            not_full, rec;
  logic [TS_W-1:0] div_a, div_b, quo;
  logic            div_done;

  assign gap      = in_data.timestamp - prev_r;
  assign not_full = cnt_r < NW'(GAP_CAPACITY);
  assign rec      = cmd.take_sample && not_full && (gap >= {32'd0, thr_r});

  // mean divide operands
  assign div_a = total_r;
  assign div_b = TS_W'(n_r);

  gdp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (quo)
  );

  always_comb begin
    for (int i = 0; i < N_LANE; i++) begin
      trial[i] = ans_r[i] | (TS_W'(1) << cmd.bit_idx);
    end
  end

  // run state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r   <= '0;
      prev_r  <= '0;
      start_r <= '0;
      cnt_r   <= '0;
      total_r <= '0;
    end else begin
      if (cfg_we) thr_r <= cfg_data;
      if (cmd.take_start) begin
        start_r <= in_data.timestamp;
        prev_r  <= in_data.timestamp;
        cnt_r   <= '0;
        total_r <= '0;
      end else if (cmd.take_sample && not_full) begin
        prev_r <= in_data.timestamp;
        if (rec) begin
          cnt_r   <= cnt_r + NW'(1);
          total_r <= total_r + gap;
        end
      end
    end
  end

  // gap store: write on record, registered read during scan
  always_ff @(posedge clk) begin
    if (rec) mem[cnt_r[AW-1:0]] <= gap;
    if (cmd.rd_en) rdata_r <= mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) rd_vld_r <= 1'b0;
    else        rd_vld_r <= cmd.rd_en;
  end

  // stop snapshot, lane ranks, mean and lanes
  always_ff @(posedge clk) begin
    if (cmd.take_stop) begin
      runtime_r        <= in_data.timestamp - start_r;
      n_r              <= cnt_r;
      k_r[LANE_MIN]    <= '0;
      k_r[LANE_MEDIAN] <= cnt_r >> 1;
      k_r[LANE_P90]    <= NW'(pct_index(21'(cnt_r), 3'(LANE_P90)));
      k_r[LANE_P99]    <= NW'(pct_index(21'(cnt_r), 3'(LANE_P99)));
      k_r[LANE_P999]   <= NW'(pct_index(21'(cnt_r), 3'(LANE_P999)));
      k_r[LANE_P9999]  <= NW'(pct_index(21'(cnt_r), 3'(LANE_P9999)));
      k_r[LANE_P99999] <= NW'(pct_index(21'(cnt_r), 3'(LANE_P99999)));
      k_r[LANE_MAX]    <= cnt_r - NW'(1);
    end
    if (cmd.div_save) mean_r <= quo;
    // address walk
    if (cmd.scan_clear || cmd.lane_update) addr_r <= '0;
    else if (cmd.rd_en)                    addr_r <= addr_r + AW'(1);
    for (int i = 0; i < N_LANE; i++) begin
      if (cmd.scan_clear) begin
        ans_r[i] <= '0;
        lt_r[i]  <= '0;
      end else if (cmd.lane_update) begin
        if (lt_r[i] <= k_r[i]) ans_r[i] <= trial[i];
        lt_r[i] <= '0;
      end else if (rd_vld_r && (rdata_r < trial[i])) begin
        lt_r[i] <= lt_r[i] + NW'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.runtime   <= runtime_r;
      out_r.gap_count <= COUNT_W'(n_r);
      out_r.gap_total <= total_r;
      if (n_r == '0) begin
        out_r.gap_min    <= '0;
        out_r.gap_median <= '0;
        out_r.gap_mean   <= '0;
        out_r.gap_p90    <= '0;
        out_r.gap_p99    <= '0;
        out_r.gap_p999   <= '0;
        out_r.gap_p9999  <= '0;
        out_r.gap_p99999 <= '0;
        out_r.gap_max    <= '0;
      end else begin
        out_r.gap_min    <= ans_r[LANE_MIN];
        out_r.gap_median <= ans_r[LANE_MEDIAN];
        out_r.gap_mean   <= mean_r;
        out_r.gap_p90    <= ans_r[LANE_P90];
        out_r.gap_p99    <= ans_r[LANE_P99];
        out_r.gap_p999   <= ans_r[LANE_P999];
        out_r.gap_p9999  <= ans_r[LANE_P9999];
        out_r.gap_p99999 <= ans_r[LANE_P99999];
        out_r.gap_max    <= ans_r[LANE_MAX];
      end
    end
  end

  assign sts.empty     = (n_r == '0);
  assign sts.div_done  = div_done;
  assign sts.addr_last = (NW'(addr_r) == n_r - NW'(1));
  assign sts.out_free  = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: rtl/core/gdp_ctrl.sv
// ----------------------------------------------------------------------------
// gdp_ctrl: sequencer for the gap detector
// Takes words in idle; on a stop with gaps recorded runs the mean divide, then
// one store pass per result bit from the top down, then loads the report.
// ----------------------------------------------------------------------------
module gdp_ctrl import gdp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_op,
  output logic       in_stall,
  input  dp_sts_t    sts,
  output dp_cmd_t    cmd
);

  ctrl_state_t state_r, state_nxt;
  logic [5:0]  bit_r, bit_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      bit_r   <= '0;
    end else begin
      state_r <= state_nxt;
      bit_r   <= bit_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt   = state_r;
    bit_nxt     = bit_r;
    cmd         = '0;
    cmd.bit_idx = bit_r;
    in_stall    = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          priority if (in_op == OP_START) begin
            cmd.take_start = 1'b1;
          end else if (in_op == OP_SAMPLE) begin
            cmd.take_sample = 1'b1;
          end else if (in_op == OP_STOP) begin
            cmd.take_stop = 1'b1;
            state_nxt     = S_CHECK;
          end else begin
            cmd.take_sample = 1'b0;
          end
        end
      end
      // nothing recorded: report at once
      S_CHECK: begin
        if (sts.empty) begin
          state_nxt = S_REPORT;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV_WAIT;
        end
      end
      S_DIV_WAIT: begin
        if (sts.div_done) begin
          cmd.div_save = 1'b1;
          state_nxt    = S_SCAN_INIT;
        end
      end
      S_SCAN_INIT: begin
        cmd.scan_clear = 1'b1;
        bit_nxt        = BIT_TOP;
        state_nxt      = S_PASS;
      end
      S_PASS: begin
        cmd.rd_en = 1'b1;
        if (sts.addr_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.lane_update = 1'b1;
        if (bit_r == '0) begin
          state_nxt = S_REPORT;
        end else begin
          bit_nxt   = bit_r - 6'd1;
          state_nxt = S_PASS;
        end
      end
      // wait for a free output register
      S_REPORT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/gdp_checker.sv
// ----------------------------------------------------------------------------
// gdp_checker: port-level checks for the gap detector
// Watches the top-level ports and is bound to every instance.
// ----------------------------------------------------------------------------
module gdp_checker import gdp_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input in_word_t    in_data,
  input logic        out_valid,
  input logic        out_stall,
  input out_word_t   out_data,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [31:0] cfg_data
);

  // a stalled report holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("report dropped or changed while stalled");

  // an accepted stop makes the block busy
  a_stop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.operation == OP_STOP |=> in_stall)
    else $error("input taken during stop report");

  // empty run reports zero min, max and mean
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.gap_count == '0 |->
      out_data.gap_min == '0 && out_data.gap_max == '0 && out_data.gap_mean == '0)
    else $error("empty run with nonzero statistics");

  // ordering of min, median and p90, and of p99999 against max
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.gap_min <= out_data.gap_median &&
      out_data.gap_median <= out_data.gap_p90 && out_data.gap_p99999 <= out_data.gap_max)
    else $error("order statistics out of order");

endmodule

bind gap_detector_with_percentile_stats gdp_checker u_gdp_checker (.*);

FILE: test/gap_detector_with_percentile_stats_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gap_detector_with_percentile_stats_test: self-checking bench for the gap monitor
// Drives start, sample and stop words with random idle and stall bursts, keeps
// its own copy of the gap store and threshold, and checks every stop report
// field by field against sorted-gap statistics.
// ----------------------------------------------------------------------------
module gap_detector_with_percentile_stats_test;
  import gdp_pkg::*;

  localparam int CAPACITY  = 512;
  localparam int IDLE_LIMIT = 200000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_word_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_word_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;

  gap_detector_with_percentile_stats #(.GAP_CAPACITY(CAPACITY)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // pending words and expected reports
  in_word_t  word_queue[$];
  out_word_t report_queue[$];

  // predictor state
  logic [63:0] threshold;
  logic [63:0] prev_stamp;
  logic [63:0] start_stamp;
  logic [63:0] gaps[CAPACITY];
  int          gap_cnt;
  logic [63:0] gap_sum;

  int  mismatches;
  int  idle_cycles;
  bit  quiet;
  bit  sending;
  bit  in_done;
  int  in_gap;
  int  out_hold;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // statistics at sorted index floor(n*num/den)
  function automatic logic [63:0] pick_sorted(ref logic [63:0] s[$], input int n,
                                              input longint num, input longint den);
    longint idx;
    idx = (longint'(n) * num) / den;
    if (idx >= n) idx = n - 1;
    return s[idx];
  endfunction

  // advance predictor by one accepted word
  task automatic predict_word(input in_word_t w);
    out_word_t   r;
    logic [63:0] g;
    logic [63:0] s[$];
    case (w.operation)
      OP_START: begin
        start_stamp = w.timestamp;
        prev_stamp  = w.timestamp;
        gap_cnt     = 0;
        gap_sum     = '0;
      end
      OP_SAMPLE: begin
        if (gap_cnt < CAPACITY) begin
          g = w.timestamp - prev_stamp;
          prev_stamp = w.timestamp;
          if (g >= threshold) begin
            gaps[gap_cnt] = g;
            gap_cnt++;
            gap_sum += g;
          end
        end
      end
      OP_STOP: begin
        r = '0;
        r.runtime   = w.timestamp - start_stamp;
        r.gap_count = gap_cnt[12:0];
        r.gap_total = gap_sum;
        if (gap_cnt > 0) begin
          for (int i = 0; i < gap_cnt; i++) s.push_back(gaps[i]);
          s.sort();
          r.gap_min    = s[0];
          r.gap_median = s[gap_cnt / 2];
          r.gap_mean   = gap_sum / gap_cnt;
          r.gap_p90    = pick_sorted(s, gap_cnt, 9, 10);
          r.gap_p99    = pick_sorted(s, gap_cnt, 99, 100);
          r.gap_p999   = pick_sorted(s, gap_cnt, 999, 1000);
          r.gap_p9999  = pick_sorted(s, gap_cnt, 9999, 10000);
          r.gap_p99999 = pick_sorted(s, gap_cnt, 99999, 100000);
          r.gap_max    = s[gap_cnt - 1];
        end
        report_queue.push_back(r);
      end
      default: ;
    endcase
  endtask

  // input driver: hold a stalled word, drop the one taken at the last edge
  always @(negedge clk) begin
    if (rst_n && !(in_valid && !in_done)) begin
      if (in_done) void'(word_queue.pop_front());
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (sending && word_queue.size() > 0) begin
        if (!quiet && $urandom_range(0, 9) == 0) begin
          in_gap = $urandom_range(0, 6);
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_data  <= word_queue[0];
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output stall bursts
  always @(negedge clk) begin
    if (out_hold > 0) begin
      out_hold--;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      out_hold = $urandom_range(0, 6);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor: predict on accepted words, check accepted reports
  always @(posedge clk) begin
    if (rst_n) begin
      idle_cycles++;
      in_done = in_valid && !in_stall;
      if (in_done) begin
        predict_word(in_data);
        idle_cycles = 0;
      end
      if (out_valid && !out_stall) begin
        idle_cycles = 0;
        if (report_queue.size() == 0) begin
          $display("%0t: report with nothing expected, actual %p", $time, out_data);
          mismatches++;
        end else begin
          check_report(report_queue.pop_front(), out_data);
        end
      end
      if (cfg_valid && cfg_ready) idle_cycles = 0;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic check_field(input string name, input logic [63:0] e, input logic [63:0] a);
    if (e !== a) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, e, a);
      mismatches++;
    end
  endtask

  task automatic check_report(input out_word_t e, input out_word_t a);
    check_field("runtime", e.runtime, a.runtime);
    check_field("gap_count", 64'(e.gap_count), 64'(a.gap_count));
    check_field("gap_min", e.gap_min, a.gap_min);
    check_field("gap_median", e.gap_median, a.gap_median);
    check_field("gap_mean", e.gap_mean, a.gap_mean);
    check_field("gap_p90", e.gap_p90, a.gap_p90);
    check_field("gap_p99", e.gap_p99, a.gap_p99);
    check_field("gap_p999", e.gap_p999, a.gap_p999);
    check_field("gap_p9999", e.gap_p9999, a.gap_p9999);
    check_field("gap_p99999", e.gap_p99999, a.gap_p99999);
    check_field("gap_max", e.gap_max, a.gap_max);
    check_field("gap_total", e.gap_total, a.gap_total);
  endtask

  function automatic in_word_t mk(input logic [1:0] op, input logic [63:0] ts);
    in_word_t w;
    w.operation = op;
    w.timestamp = ts;
    return w;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // hand the queue to the driver and wait until all reports are in
  task automatic run_and_drain();
    sending = 1'b1;
    wait (word_queue.size() == 0 && !in_valid);
    sending = 1'b0;
    wait (report_queue.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  // register write while idle
  task automatic write_threshold(input logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    threshold = 64'(value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // run: start, samples mostly in random steps plus stray words, one or two stops
  task automatic queue_run(input int samples, input int step_max);
    logic [63:0] t;
    t = ($urandom_range(0, 3) == 0) ? 64'hFFFF_FFFF_FFFF_FF00 + $urandom_range(0, 255)
                                    : rand64();
    word_queue.push_back(mk(OP_START, t));
    for (int i = 0; i < samples; i++) begin
      case ($urandom_range(0, 19))
        0: word_queue.push_back(mk(2'd3, rand64()));
        1: word_queue.push_back(mk(OP_SAMPLE, rand64()));
        default: begin
          t += $urandom_range(0, step_max);
          word_queue.push_back(mk(OP_SAMPLE, t));
        end
      endcase
    end
    word_queue.push_back(mk(OP_STOP, t + $urandom_range(0, 1000)));
    if ($urandom_range(0, 4) == 0) word_queue.push_back(mk(OP_STOP, rand64()));
  endtask

  initial begin
    int sent;
    rst_n = 1'b0; in_valid = 1'b0; in_data = '0; out_stall = 1'b0;
    cfg_valid = 1'b0; cfg_data = '0;
    threshold = '0; prev_stamp = '0; start_stamp = '0; gap_cnt = 0; gap_sum = '0;
    mismatches = 0; idle_cycles = 0; quiet = 1'b0; sending = 1'b0; in_done = 1'b0;
    in_gap = 0; out_hold = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: words before any start, extremes, unused code, repeated stop
    word_queue.push_back(mk(OP_STOP, '1));
    word_queue.push_back(mk(OP_SAMPLE, 64'd5));
    word_queue.push_back(mk(2'd3, '1));
    word_queue.push_back(mk(OP_STOP, 64'd7));
    word_queue.push_back(mk(OP_START, '1));
    word_queue.push_back(mk(OP_STOP, 64'd0));
    word_queue.push_back(mk(OP_START, 64'hFFFF_FFFF_FFFF_FFF0));
    word_queue.push_back(mk(OP_SAMPLE, 64'h5));
    word_queue.push_back(mk(OP_SAMPLE, 64'h5));
    word_queue.push_back(mk(OP_SAMPLE, 64'h8000_0000_0000_0000));
    word_queue.push_back(mk(OP_SAMPLE, 64'h4));
    word_queue.push_back(mk(OP_SAMPLE, 64'h3));
    word_queue.push_back(mk(OP_STOP, '1));
    word_queue.push_back(mk(OP_STOP, 64'h1234));
    run_and_drain();

    // threshold extremes; all-ones records only the largest gaps
    write_threshold(32'hFFFF_FFFF);
    word_queue.push_back(mk(OP_START, 64'd0));
    word_queue.push_back(mk(OP_SAMPLE, 64'hFFFF_FFFE));
    word_queue.push_back(mk(OP_SAMPLE, 64'h1_FFFF_FFFD));
    word_queue.push_back(mk(OP_SAMPLE, '1));
    word_queue.push_back(mk(OP_STOP, 64'd9));
    run_and_drain();

    // fill the store past capacity with zero threshold
    write_threshold(32'd0);
    queue_run(CAPACITY + 20, 50);
    sent = CAPACITY + 40;
    run_and_drain();

    // random phases across several thresholds
    while (sent < 1950) begin
      write_threshold($urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 400));
      for (int k = 0; k < 6; k++) begin
        int n;
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 60);
        queue_run(n, ($urandom_range(0, 1) == 0) ? 1000 : 100000);
        sent += n + 2;
        if (sent >= 1700) quiet = 1'b1;
      end
      run_and_drain();
    end
    write_threshold(32'd0);

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
